/* hw/rtl/sle_pkg.sv */
// Package with shared types and constants for the sequential list engine.
package sle_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 7;
  localparam int IDX_W = 7;
  localparam int CNT_W = 7;

  localparam logic [IDX_W-1:0] NOT_FOUND = 7'h7F;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_CLEAR  = 2'd3
  } sle_func_t;

  typedef enum logic [1:0] {
    WALK_SCAN = 2'd0,
    WALK_DOWN = 2'd1,
    WALK_UP   = 2'd2
  } walk_t;

  typedef struct packed {
    logic  load;
    logic  start_scan;
    logic  start_up;
    logic  take_hit;
    logic  walk;
    walk_t mode;
    logic  put_key;
    logic  dec_count;
    logic  clear_count;
    logic  set_res;
    logic  res_ok;
    logic  res_found;
  } sle_cmd_t;

  typedef struct packed {
    logic      match;
    logic      walk_done;
    logic      can_insert;
    sle_func_t func;
  } sle_stat_t;

endpackage

/* hw/rtl/sle_req_if.sv */
// Request channel interface of the sequential list engine.
interface sle_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [sle_pkg::KEY_W-1:0]    key;
  logic [sle_pkg::POS_W-1:0]           position;

  modport source (output valid, output func, output key, output position, input ready);
  modport sink (input valid, input func, input key, input position, output ready);
endinterface

/* hw/rtl/sle_rsp_if.sv */
// Response channel interface of the sequential list engine.
interface sle_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [sle_pkg::IDX_W-1:0]  found_index;
  logic [sle_pkg::CNT_W-1:0]         count;

  modport source (output valid, output ok, output found_index, output count, input ready);
  modport sink (input valid, input ok, input found_index, input count, output ready);
endinterface

/* hw/rtl/sle_datapath.sv */
// Datapath of the sequential list engine: entry memory, walk pointer, count and result.
module sle_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sle_pkg::sle_cmd_t                  cmd,
  output sle_pkg::sle_stat_t                 st,
  input  logic [1:0]                         req_func,
  input  logic signed [sle_pkg::KEY_W-1:0]   req_key,
  input  logic [sle_pkg::POS_W-1:0]          req_position,
  output logic                               ok,
  output logic signed [sle_pkg::IDX_W-1:0]   found_index,
  output logic [sle_pkg::CNT_W-1:0]          count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;

  logic [sle_pkg::KEY_W-1:0] mem [CAPACITY];

  logic [sle_pkg::KEY_W-1:0] key_q;
  logic [sle_pkg::POS_W-1:0] pos_q;
  sle_pkg::sle_func_t        func_q;
  logic [CW-1:0]             count_q;
  logic [CW-1:0]             ptr;
  logic [AW-1:0]             raddr_q;
  logic                      rvalid;
  logic [sle_pkg::KEY_W-1:0] rdata;
  logic                      res_ok;
  logic [sle_pkg::IDX_W-1:0] res_idx;

  logic [PW-1:0]             pos_w;
  logic [PW-1:0]             cnt_w;
  logic [PW-1:0]             ptr_w;
  logic [PW-1:0]             hit_w;
  logic                      issue;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [sle_pkg::KEY_W-1:0] wr_data;

  always_comb begin
    pos_w = PW'(pos_q);
    cnt_w = PW'(count_q);
    ptr_w = PW'(ptr);
    hit_w = PW'(raddr_q);
    case (cmd.mode)
      sle_pkg::WALK_UP: begin
        issue   = ptr_w > pos_w;
        rd_addr = AW'(ptr - 1'b1);
      end
      default: begin
        issue   = ptr < count_q;
        rd_addr = AW'(ptr);
      end
    endcase
    wr_en   = 1'b0;
    wr_addr = AW'(pos_w);
    wr_data = key_q;
    if (cmd.put_key) begin
      wr_en = 1'b1;
    end else if (cmd.walk && rvalid && (cmd.mode != sle_pkg::WALK_SCAN)) begin
      wr_en   = 1'b1;
      wr_data = rdata;
      if (cmd.mode == sle_pkg::WALK_DOWN) begin
        wr_addr = AW'(raddr_q - 1'b1);
      end else begin
        wr_addr = AW'(raddr_q + 1'b1);
      end
    end
  end

  always_comb begin
    st.match      = rvalid && (rdata == key_q);
    st.walk_done  = !rvalid && !issue;
    st.can_insert = (count_q < CW'(CAPACITY)) && (pos_w <= cnt_w);
    st.func       = func_q;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && issue) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid  <= 1'b0;
      count_q <= '0;
    end else begin
      if (cmd.take_hit || cmd.start_scan || cmd.start_up) begin
        rvalid <= 1'b0;
      end else if (cmd.walk) begin
        rvalid <= issue;
      end
      if (cmd.clear_count) begin
        count_q <= '0;
      end else if (cmd.put_key) begin
        count_q <= count_q + 1'b1;
      end else if (cmd.dec_count) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= req_key;
      pos_q  <= req_position;
      func_q <= sle_pkg::sle_func_t'(req_func);
    end
    if (cmd.take_hit) begin
      ptr <= CW'(raddr_q) + 1'b1;
    end else if (cmd.start_scan) begin
      ptr <= '0;
    end else if (cmd.start_up) begin
      ptr <= count_q;
    end else if (cmd.walk && issue) begin
      raddr_q <= rd_addr;
      if (cmd.mode == sle_pkg::WALK_UP) begin
        ptr <= ptr - 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
    if (cmd.set_res) begin
      res_ok  <= cmd.res_ok;
      res_idx <= cmd.res_found ? hit_w[sle_pkg::IDX_W-1:0] : sle_pkg::NOT_FOUND;
    end
  end

  assign ok          = res_ok;
  assign found_index = res_idx;
  assign count       = cnt_w[sle_pkg::CNT_W-1:0];

endmodule

/* hw/rtl/sle_controller.sv */
// Controller state machine of the sequential list engine.
module sle_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output sle_pkg::sle_cmd_t   cmd,
  input  sle_pkg::sle_stat_t  st
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SHIFT_DN = 6'b001000,
    S_SHIFT_UP = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.mode   = sle_pkg::WALK_SCAN;
    state_next = state;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          sle_pkg::FUNC_INSERT: begin
            if (st.can_insert) begin
              cmd.start_up = 1'b1;
              state_next   = S_SHIFT_UP;
            end else begin
              cmd.set_res = 1'b1;
              state_next  = S_RESULT;
            end
          end
          sle_pkg::FUNC_DELETE, sle_pkg::FUNC_SEARCH: begin
            cmd.start_scan = 1'b1;
            state_next     = S_SCAN;
          end
          default: begin
            cmd.clear_count = 1'b1;
            cmd.set_res     = 1'b1;
            cmd.res_ok      = 1'b1;
            state_next      = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.walk = 1'b1;
        if (st.match) begin
          if (st.func == sle_pkg::FUNC_SEARCH) begin
            cmd.set_res   = 1'b1;
            cmd.res_ok    = 1'b1;
            cmd.res_found = 1'b1;
            state_next    = S_RESULT;
          end else begin
            cmd.take_hit = 1'b1;
            state_next   = S_SHIFT_DN;
          end
        end else if (st.walk_done) begin
          cmd.set_res = 1'b1;
          state_next  = S_RESULT;
        end
      end
      S_SHIFT_DN: begin
        cmd.walk = 1'b1;
        cmd.mode = sle_pkg::WALK_DOWN;
        if (st.walk_done) begin
          cmd.dec_count = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_ok    = 1'b1;
          state_next    = S_RESULT;
        end
      end
      S_SHIFT_UP: begin
        cmd.walk = 1'b1;
        cmd.mode = sle_pkg::WALK_UP;
        if (st.walk_done) begin
          cmd.put_key = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_ok  = 1'b1;
          state_next  = S_RESULT;
        end
      end
      S_RESULT: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/sequential_list_engine.sv */
// Top level of the sequential list engine: ordered list of signed keys with a count.
// One entry per cycle is moved or compared through the entry memory (one read and one
// write port). One item at a time: the next item is taken the cycle after the result is
// taken. Synchronous reset empties the list and clears control; the entry memory is not
// cleared.
module sequential_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  sle_req_if.sink         req,
  sle_rsp_if.source       rsp
);

  sle_pkg::sle_cmd_t  cmd;
  sle_pkg::sle_stat_t st;

  sle_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .st        (st)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .req_func     (req.func),
    .req_key      (req.key),
    .req_position (req.position),
    .ok           (rsp.ok),
    .found_index  (rsp.found_index),
    .count        (rsp.count)
  );

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request and response sides active together");

  a_put_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.put_key |-> st.can_insert)
    else $error("key stored by an insert that should be rejected");

  a_fail_idx: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ok) |-> (rsp.found_index == sle_pkg::NOT_FOUND))
    else $error("failed item reports an index");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !req.ready && !rsp.valid)
    else $error("item not held after load");
`endif

endmodule

/* dv/tb_sequential_list_engine.sv */
// Testbench for sequential_list_engine with a predictor of the list operations.
module tb_sequential_list_engine;

  localparam int CAPACITY    = 64;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;
  localparam int HOLD_LEN    = 300;

  typedef logic [sle_pkg::POS_W-1:0] pos_t;

  typedef struct packed {
    logic                             ok;
    logic signed [sle_pkg::IDX_W-1:0] found_index;
    logic [sle_pkg::CNT_W-1:0]        count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  sle_req_if req_if();
  sle_rsp_if rsp_if();

  sequential_list_engine #(.CAPACITY(CAPACITY)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic signed [sle_pkg::KEY_W-1:0] list_keys [CAPACITY];
  int                               list_len;
  list_result_t                     pending_results [$];

  bit quiet;
  int hold_req;
  int hold_left;
  int cycles;
  int mismatches;
  int results_checked;
  int items_sent;
  int full_hits;
  int op_count [4];
  int ok_count [4];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, long hold-off on request.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (quiet) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0d] unexpected result ok=%0b idx=%0d count=%0d", cycles,
                   rsp_if.ok, rsp_if.found_index, rsp_if.count);
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (rsp_if.ok !== exp_r.ok || rsp_if.found_index !== exp_r.found_index ||
            rsp_if.count !== exp_r.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0d] mismatch: exp ok=%0b idx=%0d count=%0d, got ok=%0b idx=%0d count=%0d",
                     cycles, exp_r.ok, exp_r.found_index, exp_r.count,
                     rsp_if.ok, rsp_if.found_index, rsp_if.count);
        end
      end
    end
  end

  function automatic list_result_t apply_list_op(sle_pkg::sle_func_t f,
                                                 logic signed [sle_pkg::KEY_W-1:0] k,
                                                 pos_t p);
    list_result_t r;
    int hit;
    r.ok          = 1'b0;
    r.found_index = sle_pkg::NOT_FOUND;
    hit           = -1;
    for (int i = 0; i < list_len; i++)
      if (hit < 0 && list_keys[i] == k) hit = i;
    case (f)
      sle_pkg::FUNC_INSERT: begin
        if (list_len < CAPACITY && int'(p) <= list_len) begin
          for (int j = list_len; j > int'(p); j--) list_keys[j] = list_keys[j-1];
          list_keys[p] = k;
          list_len++;
          r.ok = 1'b1;
        end
      end
      sle_pkg::FUNC_DELETE: begin
        if (hit >= 0) begin
          for (int j = hit; j + 1 < list_len; j++) list_keys[j] = list_keys[j+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      sle_pkg::FUNC_SEARCH: begin
        if (hit >= 0) begin
          r.ok          = 1'b1;
          r.found_index = hit[sle_pkg::IDX_W-1:0];
        end
      end
      default: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
    endcase
    r.count = list_len[sle_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic send_op(input sle_pkg::sle_func_t f,
                         input logic signed [sle_pkg::KEY_W-1:0] k,
                         input pos_t p);
    list_result_t r;
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(99) < 35) begin
        req_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= f;
    req_if.key      <= k;
    req_if.position <= p;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    r = apply_list_op(f, k, p);
    pending_results.push_back(r);
    items_sent++;
    op_count[int'(f)]++;
    if (r.ok) ok_count[int'(f)]++;
    if (list_len == CAPACITY) full_hits++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [sle_pkg::KEY_W-1:0] pick_key(int hit_pct);
    int sel;
    sel = $urandom_range(99);
    if (list_len > 0 && $urandom_range(99) < hit_pct)
      return list_keys[$urandom_range(list_len - 1, 0)];
    if (sel < 10) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    if (sel < 30) return $signed($urandom_range(15)) - 8;
    return $signed($urandom);
  endfunction

  function automatic pos_t pick_position();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return pos_t'($urandom_range(list_len, 0));
    if (sel < 90 && list_len < 127) return pos_t'($urandom_range(127, list_len + 1));
    return pos_t'($urandom_range(127, 0));
  endfunction

  task automatic test_directed();
    send_op(sle_pkg::FUNC_SEARCH, 5, 0);
    send_op(sle_pkg::FUNC_DELETE, 5, 0);
    send_op(sle_pkg::FUNC_INSERT, 7, 1);
    send_op(sle_pkg::FUNC_INSERT, 32'sh8000_0000, 0);
    send_op(sle_pkg::FUNC_INSERT, 32'sh7FFF_FFFF, 1);
    send_op(sle_pkg::FUNC_INSERT, -1, 0);
    send_op(sle_pkg::FUNC_INSERT, 0, 2);
    send_op(sle_pkg::FUNC_INSERT, 5, 4);
    send_op(sle_pkg::FUNC_INSERT, 5, 1);
    send_op(sle_pkg::FUNC_SEARCH, 5, 0);
    send_op(sle_pkg::FUNC_DELETE, 5, 0);
    send_op(sle_pkg::FUNC_SEARCH, 5, 0);
    send_op(sle_pkg::FUNC_DELETE, 12345, 0);
    send_op(sle_pkg::FUNC_INSERT, 9, 7);
    send_op(sle_pkg::FUNC_INSERT, 9, 127);
    send_op(sle_pkg::FUNC_INSERT, 9, 64);
    send_op(sle_pkg::FUNC_SEARCH, 32'sh8000_0000, 0);
    send_op(sle_pkg::FUNC_SEARCH, 32'sh7FFF_FFFF, 0);
    send_op(sle_pkg::FUNC_SEARCH, 32'sh5555_5555, 0);
    send_op(sle_pkg::FUNC_DELETE, 32'sh8000_0000, 0);
    send_op(sle_pkg::FUNC_CLEAR, 0, 0);
    send_op(sle_pkg::FUNC_SEARCH, -1, 0);
    send_op(sle_pkg::FUNC_INSERT, 32'sh2AAA_AAAA, 0);
    send_op(sle_pkg::FUNC_INSERT, 32'shD555_5555, 0);
    send_op(sle_pkg::FUNC_DELETE, 32'sh2AAA_AAAA, 0);
    wait_all_results();
  endtask

  task automatic test_fill_to_capacity();
    quiet = 1'b1;
    send_op(sle_pkg::FUNC_CLEAR, 0, 0);
    while (list_len < CAPACITY)
      send_op(sle_pkg::FUNC_INSERT, pick_key(15), pos_t'($urandom_range(list_len, 0)));
    send_op(sle_pkg::FUNC_INSERT, 1, pos_t'(CAPACITY));
    send_op(sle_pkg::FUNC_INSERT, 1, 0);
    send_op(sle_pkg::FUNC_INSERT, 1, 127);
    send_op(sle_pkg::FUNC_SEARCH, list_keys[CAPACITY-1], 0);
    send_op(sle_pkg::FUNC_SEARCH, list_keys[0], 0);
    send_op(sle_pkg::FUNC_DELETE, list_keys[CAPACITY-1], 0);
    send_op(sle_pkg::FUNC_INSERT, 42, pos_t'(list_len));
    repeat (30) send_op(sle_pkg::FUNC_DELETE, pick_key(85), 0);
    quiet = 1'b0;
    wait_all_results();
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_LEN;
    repeat (8) begin
      if ($urandom_range(1)) send_op(sle_pkg::FUNC_INSERT, pick_key(30), pick_position());
      else send_op(sle_pkg::FUNC_SEARCH, pick_key(60), 0);
    end
    wait_all_results();
  endtask

  task automatic test_random_ops(input int n_items);
    int sel;
    for (int n = 0; n < n_items; n++) begin
      quiet = (n >= n_items / 3 && n < n_items / 3 + 200);
      sel   = $urandom_range(999);
      if (sel < 10)
        send_op(sle_pkg::FUNC_CLEAR, $signed($urandom), pos_t'($urandom_range(127, 0)));
      else if (sel < 420)
        send_op(sle_pkg::FUNC_INSERT, pick_key(20), pick_position());
      else if (sel < 700)
        send_op(sle_pkg::FUNC_DELETE, pick_key(70), pos_t'($urandom_range(127, 0)));
      else
        send_op(sle_pkg::FUNC_SEARCH, pick_key(70), pos_t'($urandom_range(127, 0)));
    end
    quiet = 1'b0;
    wait_all_results();
  endtask

  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.func     = sle_pkg::FUNC_INSERT;
    req_if.key      = '0;
    req_if.position = '0;
    list_len        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_to_capacity();
    test_backpressure();
    test_random_ops(1800);

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d items: %0d inserts (%0d ok), %0d deletes (%0d ok), %0d searches (%0d hit)",
             items_sent, op_count[0], ok_count[0], op_count[1], ok_count[1],
             op_count[2], ok_count[2]);
    $display("%0d clears, %0d results checked, list full after %0d items, %0d mismatches",
             op_count[3], results_checked, full_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
